/* src/pf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// shared widths, constants and control structs for the prime filter
// no dependencies

package pf_pkg;

	localparam int VALUE_W     = 15;  // width of a tested value
	localparam int SLOT_W      = 7;   // width of a destination slot
	localparam int DIV_W       = 8;   // trial divisors stay below 2^8 (square bound)
	localparam int SQ_W        = 16;  // square of a divisor, one past the value range
	localparam int STEP_W      = $clog2(VALUE_W);
	localparam int MAX_LEN_DEF = 128;

	localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(2);
	localparam logic [SQ_W-1:0]  FIRST_SQ  = SQ_W'(4);

	// status of the serial remainder unit
	typedef struct packed {
		logic done;  // one-cycle pulse, remainder final
		logic zero;  // remainder is zero
	} rem_status_t;

	// requests to the copy counter
	typedef struct packed {
		logic inc;
		logic clr;
	} cnt_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_FINISH = 4'b1000
	} pf_state_t;

endpackage

`default_nettype wire

/* src/prime_filter_copy.sv */
`timescale 1ns / 1ps
`default_nettype none
// top level of the prime filter: sequencer, trial divisor stepping, output register
// depends on pf_pkg, pf_rem_unit, pf_copy_counter
//
//  channel | valid / stall         | fields
//  --------+-----------------------+---------------------------------
//  in      | in_valid / in_stall   | value, last (request in)
//  out     | out_valid / out_stall | prime_value, slot (request out)
//
// one request at a time; each trial divisor passes a check state, the
// bit-serial remainder unit and a step that takes its status, and
// divisors run from 2 while d*d <= value and d <= value/2: values below 2
// skip the search, even values from 4 stop at the first divisor, and primes
// near 32767 try the most divisors. the remainder unit sets the cost per divisor.
// reset clears the sequencer, the copy count and the output valid.
// a result held by out_stall does not block the next input request; only
// a new prime that finds the output register still full waits for it.

module prime_filter_copy #(
	parameter int MAX_LEN = pf_pkg::MAX_LEN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [pf_pkg::VALUE_W-1:0]  value,
	input  wire logic                        last,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [pf_pkg::VALUE_W-1:0]       prime_value,
	output logic [pf_pkg::SLOT_W-1:0]        slot
);
	import pf_pkg::*;

	pf_state_t          state_q;
	logic [VALUE_W-1:0] value_q;
	logic               last_q;
	logic               prime_q;
	logic [DIV_W-1:0]   div_q;
	logic [SQ_W-1:0]    sq_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] prime_value_q;
	logic [SLOT_W-1:0]  slot_q;

	logic               accept;
	logic               rem_start;
	rem_status_t        rem_status;
	cnt_ctl_t           cnt_ctl;
	logic [SLOT_W-1:0]  cnt_slot;
	logic               cnt_full;
	logic               out_free;
	logic               search_over;
	logic               emit;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// no divisor left: past half the value, or square beyond the value
	assign search_over = ({{(VALUE_W-1-DIV_W){1'b0}}, div_q} > value_q[VALUE_W-1:1])
		|| (sq_q > {{(SQ_W-VALUE_W){1'b0}}, value_q});

	assign rem_start = (state_q == ST_CHECK) && !search_over;

	// a prime with room goes out once the output register can take it
	assign emit = (state_q == ST_FINISH) && prime_q && !cnt_full && out_free;

	assign cnt_ctl.inc = emit;
	assign cnt_ctl.clr = (state_q == ST_FINISH) && last_q
		&& (!prime_q || cnt_full || out_free);

	pf_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (value_q),
		.divisor  (div_q),
		.status   (rem_status)
	);

	pf_copy_counter #(
		.MAX_LEN (MAX_LEN)
	) u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cnt_ctl),
		.slot   (cnt_slot),
		.full   (cnt_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// values below two are never prime
						state_q <= (value < VALUE_W'(2)) ? ST_FINISH : ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= search_over ? ST_FINISH : ST_DIV;
				end
				ST_DIV: begin
					if (rem_status.done) begin
						state_q <= rem_status.zero ? ST_FINISH : ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (!prime_q || cnt_full || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
			last_q  <= last;
			prime_q <= 1'b0;
			div_q   <= FIRST_DIV;
			sq_q    <= FIRST_SQ;
		end else if (state_q == ST_CHECK && search_over) begin
			prime_q <= 1'b1;
		end else if (state_q == ST_DIV && rem_status.done && !rem_status.zero) begin
			// (d+1)^2 = d^2 + 2d + 1
			div_q <= div_q + DIV_W'(1);
			sq_q  <= sq_q + {{(SQ_W-DIV_W-1){1'b0}}, div_q, 1'b1};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			prime_value_q <= value_q;
			slot_q        <= cnt_slot;
		end
	end

	assign out_valid   = out_valid_q;
	assign prime_value = prime_value_q;
	assign slot        = slot_q;

endmodule

`default_nettype wire

/* src/pf_rem_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// bit-serial remainder unit: one dividend bit per cycle, restoring step
// depends on pf_pkg

module pf_rem_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pf_pkg::VALUE_W-1:0]  dividend,
	input  wire logic [pf_pkg::DIV_W-1:0]    divisor,
	output pf_pkg::rem_status_t              status
);
	import pf_pkg::*;

	logic [VALUE_W-1:0] shift_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIV_W-1:0]   r_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_W:0]     trial;
	logic [DIV_W:0]     r_next;

	// shift in next dividend bit, subtract divisor when it fits
	always_comb begin
		trial  = {r_q, shift_q[VALUE_W-1]};
		r_next = trial;
		if (trial >= {1'b0, div_q}) begin
			r_next = trial - {1'b0, div_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			div_q   <= divisor;
			r_q     <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[VALUE_W-2:0], 1'b0};
			r_q     <= r_next[DIV_W-1:0];
		end
	end

	assign status.done = done_q;
	assign status.zero = (r_q == '0);

endmodule

`default_nettype wire

/* src/pf_copy_counter.sv */
`timescale 1ns / 1ps
`default_nettype none
// saturating copy counter giving the destination slot
// depends on pf_pkg

module pf_copy_counter #(
	parameter int MAX_LEN = pf_pkg::MAX_LEN_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pf_pkg::cnt_ctl_t           ctl,
	output logic [pf_pkg::SLOT_W-1:0]       slot,
	output logic                            full
);
	import pf_pkg::*;

	localparam int CNT_W = $clog2(MAX_LEN + 1);

	logic [CNT_W-1:0]        count_q;
	logic [SLOT_W+CNT_W-1:0] count_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clr) begin
			count_q <= '0;
		end else if (ctl.inc && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// low slot bits of the count, zero padded when the count is narrow
	assign count_ext = {{SLOT_W{1'b0}}, count_q};
	assign slot      = count_ext[SLOT_W-1:0];
	assign full      = (count_q == CNT_W'(MAX_LEN));

endmodule

`default_nettype wire
